### design/mmm_pkg.sv
package mmm_pkg;

    // operand and stream geometry
    localparam int OPERAND_BITS = 2048;
    localparam int IN_WORDS     = 128;
    localparam int OUT_WORDS    = 64;
    localparam int CHUNK_BITS   = 16;
    localparam int WORD_BITS    = 32;
    localparam int IN_TDATA_W   = 2 * CHUNK_BITS;
    localparam int OUT_TDATA_W  = WORD_BITS;

    // derived widths
    localparam int LOAD_BITS   = IN_WORDS * CHUNK_BITS;
    localparam int EXT_BITS    = (LOAD_BITS >= OPERAND_BITS) ? LOAD_BITS : OPERAND_BITS;
    localparam int ACC_W       = OPERAND_BITS + 2;
    localparam int OUT_BITS    = OUT_WORDS * WORD_BITS;
    localparam int LOAD_CNT_W  = $clog2(IN_WORDS);
    localparam int BIT_CNT_W   = $clog2(OPERAND_BITS);
    localparam int OUT_CNT_W   = $clog2(OUT_WORDS);

    // modulus: 256-bit pattern repeated, cut to the operand width
    localparam int PATTERN_BITS = 256;
    localparam logic [PATTERN_BITS-1:0] PATTERN =
        256'hffffffff00000001000000020000000300000004fffffffffffffffffffffff1;

    function automatic logic [OPERAND_BITS-1:0] f_modulus();
        logic [OPERAND_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < OPERAND_BITS; i++) begin
            m[i] = PATTERN[8'(i % PATTERN_BITS)];
        end
        return m;
    endfunction

    localparam logic [OPERAND_BITS-1:0] MODULUS = f_modulus();

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ADD_X,
        ST_ADD_N,
        ST_REDUCE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;     // shift one input chunk pair in
        logic clear;    // zero the accumulator
        logic add_x;    // acc += y_i ? X : 0, advance y
        logic add_n;    // acc = (acc + u*N) / 2
        logic reduce;   // acc -= N when acc >= N
        logic to_out;   // move reduced acc into the output register
        logic out_pop;  // one output transfer done
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } t_sts;

endpackage

### design/mmm_ctrl.sv
module mmm_ctrl import mmm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [LOAD_CNT_W-1:0] LOAD_LAST = LOAD_CNT_W'(IN_WORDS - 1);
    localparam logic [BIT_CNT_W-1:0]  BIT_LAST  = BIT_CNT_W'(OPERAND_BITS - 1);

    t_state r_state, n_state;
    logic [LOAD_CNT_W-1:0] r_load_cnt, n_load_cnt;
    logic [BIT_CNT_W-1:0]  r_bit_cnt, n_bit_cnt;
    logic w_load_last, w_bit_last, w_in_xfer;

    assign w_load_last = (r_load_cnt == LOAD_LAST);
    assign w_bit_last  = (r_bit_cnt == BIT_LAST);
    // the completing item waits until the previous result has drained
    assign o_in_ready  = (r_state == ST_LOAD) && (!w_load_last || !i_sts.out_busy);
    assign w_in_xfer   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_load_cnt <= '0;
            r_bit_cnt  <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_bit_cnt  <= n_bit_cnt;
        end
    end

    // next state and counters
    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_bit_cnt  = r_bit_cnt;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_xfer) begin
                    if (w_load_last) begin
                        n_load_cnt = '0;
                        n_state    = ST_ADD_X;
                    end else begin
                        n_load_cnt = r_load_cnt + 1'b1;
                    end
                end
            end
            ST_ADD_X: n_state = ST_ADD_N;
            ST_ADD_N: n_state = ST_REDUCE;
            ST_REDUCE: begin
                if (w_bit_last) begin
                    n_bit_cnt = '0;
                    n_state   = ST_LOAD;
                end else begin
                    n_bit_cnt = r_bit_cnt + 1'b1;
                    n_state   = ST_ADD_X;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.out_pop = i_sts.out_busy && i_out_ready;
        unique case (r_state)
            ST_LOAD: begin
                o_cmd.load  = w_in_xfer;
                o_cmd.clear = w_in_xfer && w_load_last;
            end
            ST_ADD_X:  o_cmd.add_x = 1'b1;
            ST_ADD_N:  o_cmd.add_n = 1'b1;
            ST_REDUCE: begin
                o_cmd.reduce = 1'b1;
                o_cmd.to_out = w_bit_last;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

### design/mmm_dp.sv
module mmm_dp import mmm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    output logic [OUT_TDATA_W-1:0] o_out_data,
    output logic                   o_out_last,
    output t_sts                   o_sts
);

    localparam logic [OUT_CNT_W-1:0] OUT_LAST = OUT_CNT_W'(OUT_WORDS - 1);

    logic [LOAD_BITS-1:0]    r_x, r_y;
    logic [ACC_W-1:0]        r_acc;
    logic [OUT_BITS-1:0]     r_out;
    logic [OUT_CNT_W-1:0]    r_out_cnt;
    logic                    r_out_busy;

    logic [EXT_BITS-1:0]     w_x_ext;
    logic [OPERAND_BITS-1:0] w_x;
    logic [ACC_W-1:0]        w_sum_x;
    logic [ACC_W:0]          w_sum_n;
    logic [ACC_W:0]          w_diff;
    logic [ACC_W-1:0]        w_reduced;

    // operand bits above the loaded chunks read as zero
    assign w_x_ext = EXT_BITS'(r_x);
    assign w_x     = w_x_ext[OPERAND_BITS-1:0];

    // one full-width adder pass per cycle
    assign w_sum_x   = r_acc + (r_y[0] ? ACC_W'(w_x) : '0);
    assign w_sum_n   = {1'b0, r_acc} + (r_acc[0] ? (ACC_W + 1)'(MODULUS) : '0);
    assign w_diff    = {1'b0, r_acc} - (ACC_W + 1)'(MODULUS);
    assign w_reduced = w_diff[ACC_W] ? r_acc : w_diff[ACC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= {i_in_data[CHUNK_BITS-1:0], r_x[LOAD_BITS-1:CHUNK_BITS]};
            r_y <= {i_in_data[IN_TDATA_W-1:CHUNK_BITS], r_y[LOAD_BITS-1:CHUNK_BITS]};
        end else if (i_cmd.add_x) begin
            r_y <= r_y >> 1;
        end

        if (i_cmd.clear) begin
            r_acc <= '0;
        end else if (i_cmd.add_x) begin
            r_acc <= w_sum_x;
        end else if (i_cmd.add_n) begin
            r_acc <= w_sum_n[ACC_W:1];
        end else if (i_cmd.reduce) begin
            r_acc <= w_reduced;
        end

        if (i_cmd.to_out) begin
            r_out <= OUT_BITS'(w_reduced);
        end else if (i_cmd.out_pop) begin
            r_out <= r_out >> WORD_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_busy <= 1'b0;
            r_out_cnt  <= '0;
        end else if (i_cmd.to_out) begin
            r_out_busy <= 1'b1;
            r_out_cnt  <= '0;
        end else if (i_cmd.out_pop) begin
            if (r_out_cnt == OUT_LAST) begin
                r_out_busy <= 1'b0;
                r_out_cnt  <= '0;
            end else begin
                r_out_cnt <= r_out_cnt + 1'b1;
            end
        end
    end

    assign o_out_data     = r_out[WORD_BITS-1:0];
    assign o_out_last     = (r_out_cnt == OUT_LAST);
    assign o_sts.out_busy = r_out_busy;

endmodule

### design/montgomery_modmul_2048.sv
// radix-2 montgomery multiplier over a fixed 2048-bit odd modulus n (a 256-bit pattern
// repeated). operands x and y arrive as 128 input transfers, each carrying 16 bits of x
// and 16 bits of y, least significant chunk first. the 128th transfer starts the product:
// 2048 steps, one per bit of y from bit 0 up, each stepping through the phases add x,
// add n and halve, conditional subtract of n, each with its own full-width adder. the
// result s = x*y*2^-2048 (with the per-step reduction) then leaves as 64 output
// transfers of 32 bits, least significant first, tlast on the final word. loading of
// the next operands overlaps with draining of the result; the completing input transfer
// is held off until the previous result is fully taken. no input is accepted while a
// product is being computed.
module montgomery_modmul_2048 import mmm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // x_chunk[15:0], y_chunk[31:16]
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // result_word[31:0]
    output logic                   m_axis_tlast    // last_word
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: load count, bit count, step phases
    mmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // operand shift registers, accumulator, output register
    mmm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_data  (s_axis_tdata),
        .o_out_data (m_axis_tdata),
        .o_out_last (m_axis_tlast),
        .o_sts      (w_sts)
    );

    // result words are valid while the output register still holds some
    assign m_axis_tvalid = w_sts.out_busy;

endmodule
